// ===== design/rgb_fade_pwm_generator_top_defines.svh =====
// assertion macros used by the rgb fade pwm engine
`ifndef RGB_FADE_PWM_GENERATOR_TOP_DEFINES_SVH
`define RGB_FADE_PWM_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RGBF_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("rgbf assertion failed");
`define RGBF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rgbf assertion failed");
`else
`define RGBF_ASSERT(label, cond)
`define RGBF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/rgbf_pkg.sv =====
`timescale 1ns / 1ps

package rgbf_pkg;

   localparam int CNT_W      = 16;
   localparam int STEP_W     = 8;
   localparam int LEN_W      = 11;
   localparam int FCNT_W     = 14;
   localparam int PHASE_W    = 3;
   localparam int PIN_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_PHASES = 6;

   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [STEP_W-1:0]  step_type;
   typedef logic [FCNT_W-1:0]  fcnt_type;
   typedef logic [PHASE_W-1:0] phase_type;
   typedef logic [PIN_W-1:0]   pins_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD_TOP      = 3'd0,
      CSR_FADE_STEP       = 3'd1,
      CSR_PHASE_LENGTH    = 3'd2,
      CSR_COMPARE_A_START = 3'd3,
      CSR_COMPARE_B_START = 3'd4
   } csr_index_type;

   localparam count_type PERIOD_TOP_RESET   = 16'd1000;
   localparam step_type  FADE_STEP_RESET    = 8'd3;
   localparam int        PHASE_LENGTH_RESET = 300;
   localparam count_type COMPARE_A_RESET    = 16'd30;
   localparam count_type COMPARE_B_RESET    = 16'd930;
   localparam fcnt_type  FADE_COUNT_START   = 14'd1;
   localparam phase_type PHASE_NONE         = 3'd6;

   typedef struct packed {
      count_type                     period_top;
      step_type                      fade_step;
      fcnt_type [NUM_PHASES-1:0]     threshold;
   } cfg_type;

   typedef struct packed {
      logic      load_a;
      logic      load_b;
      count_type value;
   } load_type;

   // first phase whose upper bound covers the fade count
   function automatic phase_type fade_phase(fcnt_type c, fcnt_type [NUM_PHASES-1:0] thr);
      phase_type ph;
      ph = PHASE_NONE;
      for (int k = NUM_PHASES - 1; k >= 0; k--) begin
         if (c <= thr[k]) begin
            ph = PHASE_W'(k);
         end
      end
      return ph;
   endfunction

   function automatic pins_type a_pin(phase_type ph);
      pins_type p;
      case (ph)
         3'd0: p = 3'b010;
         3'd1: p = 3'b100;
         3'd2: p = 3'b100;
         3'd3: p = 3'b001;
         3'd4: p = 3'b001;
         3'd5: p = 3'b010;
         default: p = 3'b000;
      endcase
      return p;
   endfunction

   function automatic pins_type b_pin(phase_type ph);
      pins_type p;
      case (ph)
         3'd0: p = 3'b001;
         3'd1: p = 3'b001;
         3'd2: p = 3'b010;
         3'd3: p = 3'b010;
         3'd4: p = 3'b100;
         3'd5: p = 3'b100;
         default: p = 3'b000;
      endcase
      return p;
   endfunction

endpackage

// ===== design/rgbf_cfg.sv =====
`timescale 1ns / 1ps

module rgbf_cfg
   import rgbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg,
   output load_type              load
);

   count_type                 period_top_ff, period_top_in;
   step_type                  fade_step_ff, fade_step_in;
   fcnt_type [NUM_PHASES-1:0] threshold_ff, threshold_in;

   always_comb begin
      period_top_in = period_top_ff;
      fade_step_in  = fade_step_ff;
      threshold_in  = threshold_ff;
      load          = '0;
      load.value    = csr_write_data[CNT_W-1:0];
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PERIOD_TOP: period_top_in = csr_write_data[CNT_W-1:0];
            CSR_FADE_STEP:  fade_step_in = csr_write_data[STEP_W-1:0];
            CSR_PHASE_LENGTH: begin
               // phase bounds are multiples of the phase length
               for (int k = 0; k < NUM_PHASES; k++) begin
                  threshold_in[k] = FCNT_W'((k + 1) * csr_write_data[LEN_W-1:0]);
               end
            end
            CSR_COMPARE_A_START: load.load_a = 1'b1;
            CSR_COMPARE_B_START: load.load_b = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_top_ff <= PERIOD_TOP_RESET;
         fade_step_ff  <= FADE_STEP_RESET;
         for (int k = 0; k < NUM_PHASES; k++) begin
            threshold_ff[k] <= FCNT_W'((k + 1) * PHASE_LENGTH_RESET);
         end
      end else begin
         period_top_ff <= period_top_in;
         fade_step_ff  <= fade_step_in;
         threshold_ff  <= threshold_in;
      end
   end

   assign cfg.period_top = period_top_ff;
   assign cfg.fade_step  = fade_step_ff;
   assign cfg.threshold  = threshold_ff;

endmodule

// ===== design/rgbf_engine.sv =====
`timescale 1ns / 1ps
`include "rgb_fade_pwm_generator_top_defines.svh"

module rgbf_engine
   import rgbf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     pwm_tick,
   input  logic     fade_tick,
   input  cfg_type  cfg,
   input  load_type load,
   output pins_type pins_next
);

   count_type pwm_counter_ff, pwm_counter_in;
   count_type compare_a_ff, compare_a_in;
   count_type compare_b_ff, compare_b_in;
   fcnt_type  fade_counter_ff, fade_counter_in;
   pins_type  pin_levels_ff, pin_levels_in;

   phase_type ph_cur;
   phase_type ph_new;
   count_type step_ext;
   count_type cmp_a_f;
   count_type cmp_b_f;
   fcnt_type  fcnt_f;
   count_type cnt_p;
   pins_type  pins_p;
   logic      wrapped;

   always_comb begin
      step_ext = {{(CNT_W - STEP_W){1'b0}}, cfg.fade_step};
      ph_cur   = fade_phase(fade_counter_ff, cfg.threshold);

      // fade step first
      cmp_a_f = compare_a_ff;
      cmp_b_f = compare_b_ff;
      fcnt_f  = fade_counter_ff;
      if (fade_tick) begin
         if (ph_cur != PHASE_NONE) begin
            if (!ph_cur[0]) begin
               cmp_a_f = compare_a_ff + step_ext;
               cmp_b_f = compare_b_ff - step_ext;
            end else begin
               cmp_a_f = compare_a_ff - step_ext;
               cmp_b_f = compare_b_ff + step_ext;
            end
            fcnt_f = fade_counter_ff + FCNT_W'(1);
         end else begin
            fcnt_f = FADE_COUNT_START;
         end
      end

      // then the pwm count with the updated compares and phase
      ph_new  = fade_phase(fcnt_f, cfg.threshold);
      wrapped = (pwm_counter_ff == cfg.period_top);
      cnt_p   = pwm_counter_ff;
      pins_p  = pin_levels_ff;
      if (pwm_tick) begin
         cnt_p = wrapped ? '0 : pwm_counter_ff + CNT_W'(1);
         if (cnt_p == cmp_a_f) begin
            pins_p = pins_p | a_pin(ph_new);
         end
         if (cnt_p == cmp_b_f) begin
            pins_p = pins_p | b_pin(ph_new);
         end
         if (wrapped) begin
            pins_p = '0;
         end
      end

      pins_next = pins_p;

      pwm_counter_in  = pwm_counter_ff;
      compare_a_in    = compare_a_ff;
      compare_b_in    = compare_b_ff;
      fade_counter_in = fade_counter_ff;
      pin_levels_in   = pin_levels_ff;
      if (advance) begin
         pwm_counter_in  = cnt_p;
         compare_a_in    = cmp_a_f;
         compare_b_in    = cmp_b_f;
         fade_counter_in = fcnt_f;
         pin_levels_in   = pins_p;
      end
      if (load.load_a) begin
         compare_a_in = load.value;
      end
      if (load.load_b) begin
         compare_b_in = load.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_counter_ff  <= '0;
         compare_a_ff    <= COMPARE_A_RESET;
         compare_b_ff    <= COMPARE_B_RESET;
         fade_counter_ff <= FADE_COUNT_START;
         pin_levels_ff   <= '0;
      end else begin
         pwm_counter_ff  <= pwm_counter_in;
         compare_a_ff    <= compare_a_in;
         compare_b_ff    <= compare_b_in;
         fade_counter_ff <= fade_counter_in;
         pin_levels_ff   <= pin_levels_in;
      end
   end

   `RGBF_ASSERT(a_fade_count_nonzero, fade_counter_ff != '0)
   `RGBF_ASSERT_NEXT(a_idle_holds_count, !advance, $stable(pwm_counter_ff) && $stable(pin_levels_ff))
   `RGBF_ASSERT_NEXT(a_wrap_clears, advance && pwm_tick && wrapped, (pwm_counter_ff == '0) && (pin_levels_ff == '0))
   `RGBF_ASSERT_NEXT(a_no_fade_holds_phase, advance && !fade_tick && !load.load_a && !load.load_b, $stable(fade_counter_ff) && $stable(compare_a_ff))

endmodule

// ===== design/rgb_fade_pwm_generator_top.sv =====
`timescale 1ns / 1ps
// rgb color fade pwm generator
// input channel req_*: one beat per timer tick, carrying pwm_tick and fade_tick.
// result channel rsp_*: one beat per input beat, the three pin levels after that tick.
// configuration port csr_*: single-cycle writes of period_top, fade_step, phase_length,
// compare_a_start and compare_b_start; writing a start value also loads that compare.
// a beat accepted into the input register is offered on rsp_* from the result register.
// throughput: one beat per cycle while rsp_ready is high; the fade step, the pwm count
// and the pin match are all combinational between the input and the result register.
// reset: counters to zero, fade count to one, compares to 30 and 930, pins low,
// registers to their documented defaults, both channels empty.
// stall: when rsp_ready is low the result register holds its beat, the input register
// may still take one more beat, and req_ready drops once both are full.
module rgb_fade_pwm_generator_top
   import rgbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_pwm_tick,
   input  logic                  req_fade_tick,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_pin_zero,
   output logic                  rsp_pin_one,
   output logic                  rsp_pin_two,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic     in_valid_ff, in_valid_in;
   logic     in_pwm_ff, in_pwm_in;
   logic     in_fade_ff, in_fade_in;
   logic     out_valid_ff, out_valid_in;
   pins_type out_pins_ff, out_pins_in;
   logic     advance;
   pins_type pins_next;
   cfg_type  cfg;
   load_type load;

   rgbf_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .load             (load)
   );

   rgbf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .pwm_tick  (in_pwm_ff),
      .fade_tick (in_fade_ff),
      .cfg       (cfg),
      .load      (load),
      .pins_next (pins_next)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_pwm_in    = in_pwm_ff;
      in_fade_in   = in_fade_ff;
      out_valid_in = out_valid_ff;
      out_pins_in  = out_pins_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_pwm_in   = req_pwm_tick;
         in_fade_in  = req_fade_tick;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_pins_in  = pins_next;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_pwm_ff   <= in_pwm_in;
      in_fade_ff  <= in_fade_in;
      out_pins_ff <= out_pins_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_pin_zero = out_pins_ff[0];
   assign rsp_pin_one  = out_pins_ff[1];
   assign rsp_pin_two  = out_pins_ff[2];

endmodule

// ===== test/rgb_fade_pwm_generator_top_tb.sv =====
`timescale 1ns / 1ps

module rgb_fade_pwm_generator_top_tb;
   import rgbf_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_IDLE      = 17;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_PHASES = 12;
   localparam int BEATS_PER_SET = 140;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_pwm_tick;
   logic                  req_fade_tick;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_pin_zero;
   logic                  rsp_pin_one;
   logic                  rsp_pin_two;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // predicted block state
   count_type        period_top_q;
   step_type         fade_step_q;
   logic [LEN_W-1:0] phase_len_q;
   count_type        cmp_a_q;
   count_type        cmp_b_q;
   count_type        pwm_count_q;
   fcnt_type         fade_count_q;
   pins_type         pin_levels_q;

   pins_type pin_levels_due[$];
   int       fail_count;
   int       cycle_count;
   bit       no_idle;

   rgb_fade_pwm_generator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pwm_tick     (req_pwm_tick),
      .req_fade_tick    (req_fade_tick),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pin_zero     (rsp_pin_zero),
      .rsp_pin_one      (rsp_pin_one),
      .rsp_pin_two      (rsp_pin_two),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic phase_type ramp_phase(fcnt_type c);
      phase_type ph;
      int        k;
      ph = PHASE_NONE;
      for (k = 0; k < NUM_PHASES; k++) begin
         if (ph == PHASE_NONE && int'(c) <= (k + 1) * int'(phase_len_q)) begin
            ph = phase_type'(k);
         end
      end
      return ph;
   endfunction

   // fade step first, then the pwm count and pin match
   function automatic pins_type next_pin_levels(bit pwm, bit fade);
      phase_type ph;
      bit        wrapped;
      if (fade) begin
         ph = ramp_phase(fade_count_q);
         if (ph == PHASE_NONE) begin
            fade_count_q = FADE_COUNT_START;
         end else begin
            if (ph[0] == 1'b0) begin
               cmp_a_q = cmp_a_q + fade_step_q;
               cmp_b_q = cmp_b_q - fade_step_q;
            end else begin
               cmp_a_q = cmp_a_q - fade_step_q;
               cmp_b_q = cmp_b_q + fade_step_q;
            end
            fade_count_q = fade_count_q + 1'b1;
         end
      end
      if (pwm) begin
         ph = ramp_phase(fade_count_q);
         wrapped = (pwm_count_q == period_top_q);
         pwm_count_q = wrapped ? '0 : pwm_count_q + 1'b1;
         if (pwm_count_q == cmp_a_q) begin
            case (ph)
               3'd0, 3'd5: pin_levels_q = pin_levels_q | 3'b010;
               3'd1, 3'd2: pin_levels_q = pin_levels_q | 3'b100;
               3'd3, 3'd4: pin_levels_q = pin_levels_q | 3'b001;
               default: ;
            endcase
         end
         if (pwm_count_q == cmp_b_q) begin
            case (ph)
               3'd0, 3'd1: pin_levels_q = pin_levels_q | 3'b001;
               3'd2, 3'd3: pin_levels_q = pin_levels_q | 3'b010;
               3'd4, 3'd5: pin_levels_q = pin_levels_q | 3'b100;
               default: ;
            endcase
         end
         if (wrapped) begin
            pin_levels_q = '0;
         end
      end
      return pin_levels_q;
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_PERIOD_TOP:      period_top_q = data;
         CSR_FADE_STEP:       fade_step_q = data[STEP_W-1:0];
         CSR_PHASE_LENGTH:    phase_len_q = data[LEN_W-1:0];
         CSR_COMPARE_A_START: cmp_a_q = data;
         CSR_COMPARE_B_START: cmp_b_q = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input count_type top, input logic [CSR_DATA_W-1:0] step_word,
                             input logic [CSR_DATA_W-1:0] len_word, input count_type a,
                             input count_type b);
      csr_write(CSR_PERIOD_TOP, top);
      csr_write(CSR_FADE_STEP, step_word);
      csr_write(CSR_PHASE_LENGTH, len_word);
      csr_write(CSR_COMPARE_A_START, a);
      csr_write(CSR_COMPARE_B_START, b);
   endtask

   task automatic send_beat(input bit pwm, input bit fade);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pwm_tick <= pwm;
      req_fade_tick <= fade;
      do @(posedge clock); while (!req_ready);
      pin_levels_due.push_back(next_pin_levels(pwm, fade));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pin_levels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_beat(1'b1, 1'b1);
      send_beat(1'b0, 1'b1);
      send_beat(1'b1, 1'b0);
   endtask

   task automatic test_fade_and_match();
      wait_idle();
      set_config(16'd6, 16'd1, 16'd2, 16'd2, 16'd4);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b1);
      send_beat(1'b0, 1'b1);
      send_beat(1'b1, 1'b1);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b1);
      send_beat(1'b0, 1'b0);
   endtask

   // compare at zero matches on the wrap itself, compare b sits above top
   task automatic test_match_on_wrap();
      wait_idle();
      csr_write(CSR_PERIOD_TOP, 16'd2);
      csr_write(CSR_COMPARE_A_START, 16'd0);
      repeat (3) send_beat(1'b1, 1'b0);
   endtask

   task automatic test_zero_period();
      wait_idle();
      csr_write(CSR_PERIOD_TOP, 16'd0);
      csr_write(CSR_COMPARE_B_START, 16'd0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b1);
      send_beat(1'b1, 1'b0);
   endtask

   task automatic test_zero_phase_length();
      wait_idle();
      set_config(16'd5, 16'd1, 16'd0, 16'd1, 16'd2);
      send_beat(1'b0, 1'b1);
      send_beat(1'b1, 1'b1);
      send_beat(1'b1, 1'b1);
   endtask

   // upper data bits set on the narrow registers, then phase length lowered under the count
   task automatic test_fade_count_beyond_range();
      wait_idle();
      set_config(16'd4, 16'hFF01, 16'hF802, 16'd1, 16'd2);
      repeat (6) send_beat(1'b0, 1'b1);
      wait_idle();
      csr_write(CSR_PHASE_LENGTH, 16'd1);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b1);
      send_beat(1'b1, 1'b0);
   endtask

   // counter left above a lowered top keeps counting without a clear
   task automatic test_counter_above_top();
      wait_idle();
      set_config(16'd40, 16'd0, 16'd1000, 16'd30, 16'd0);
      repeat (20) send_beat(1'b1, 1'b0);
      wait_idle();
      csr_write(CSR_PERIOD_TOP, 16'd5);
      repeat (24) send_beat(1'b1, 1'b0);
   endtask

   task automatic test_random_settings();
      int                    p;
      int                    n;
      count_type             top;
      count_type             a;
      count_type             b;
      logic [CSR_DATA_W-1:0] step_word;
      logic [CSR_DATA_W-1:0] len_word;
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         if (p == 0) begin
            set_config(16'hFFFF, 16'h00FF, 16'h07FF, 16'h0000, 16'hFFFF);
         end else if (p == 1) begin
            set_config(16'd1, 16'hFF00, 16'h0001, 16'd1, 16'd0);
         end else begin
            top = ($urandom_range(0, 7) == 0) ? count_type'($urandom)
                                             : count_type'($urandom_range(1, 48));
            step_word = CSR_DATA_W'($urandom);
            step_word[STEP_W-1:0] = ($urandom_range(0, 1) == 0)
                                    ? STEP_W'($urandom_range(0, 3))
                                    : STEP_W'($urandom_range(0, 255));
            len_word = CSR_DATA_W'($urandom);
            len_word[LEN_W-1:0] = ($urandom_range(0, 15) == 0)
                                  ? LEN_W'($urandom_range(0, 2047))
                                  : LEN_W'($urandom_range(1, 6));
            a = ($urandom_range(0, 5) == 0) ? count_type'($urandom)
                                           : count_type'($urandom_range(0, top));
            b = ($urandom_range(0, 5) == 0) ? count_type'($urandom)
                                           : count_type'($urandom_range(0, top));
            set_config(top, step_word, len_word, a, b);
         end
         no_idle = (p > 1) && ($urandom_range(0, 3) == 0);
         for (n = 0; n < BEATS_PER_SET; n++) begin
            if ($urandom_range(0, 63) == 0) begin
               wait_idle();
            end
            send_beat($urandom_range(0, 9) != 0, $urandom_range(0, 2) == 0);
         end
      end
      no_idle = 1'b0;
   endtask

   // result side: random stall per beat, then compare with the oldest prediction
   initial begin
      int       stall;
      pins_type want;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pin_levels_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("unexpected result beat: pins two/one/zero %b%b%b",
                        rsp_pin_two, rsp_pin_one, rsp_pin_zero);
            end
         end else begin
            want = pin_levels_due.pop_front();
            if (rsp_pin_zero !== want[0] || rsp_pin_one !== want[1] ||
                rsp_pin_two !== want[2]) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("pin mismatch: expected two/one/zero %b%b%b, got %b%b%b",
                           want[2], want[1], want[0], rsp_pin_two, rsp_pin_one, rsp_pin_zero);
               end
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pwm_tick <= 1'b0;
      req_fade_tick <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_PERIOD_TOP;
      csr_write_data <= '0;
      no_idle = 1'b0;
      period_top_q = PERIOD_TOP_RESET;
      fade_step_q = FADE_STEP_RESET;
      phase_len_q = LEN_W'(PHASE_LENGTH_RESET);
      cmp_a_q = COMPARE_A_RESET;
      cmp_b_q = COMPARE_B_RESET;
      pwm_count_q = '0;
      fade_count_q = FADE_COUNT_START;
      pin_levels_q = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_fade_and_match();
      test_match_on_wrap();
      test_zero_period();
      test_zero_phase_length();
      test_fade_count_beyond_range();
      test_counter_above_top();
      test_random_settings();
      wait_idle();

      if (fail_count == 0 && pin_levels_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== rgb_fade_pwm_generator_top.f =====
+incdir+design
design/rgbf_pkg.sv
design/rgbf_cfg.sv
design/rgbf_engine.sv
design/rgb_fade_pwm_generator_top.sv
test/rgb_fade_pwm_generator_top_tb.sv
